/* sv/xcfr_pkg.sv */
// Shared types and constants for the XOR-checked frame receiver.
`default_nettype none

package xcfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hBB;

    localparam int DEFAULT_PAYLOAD_BYTES = 64;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR2 = 2'd1,
        PH_DATA = 2'd2,
        PH_CSUM = 2'd3
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        logic       checksum_good;
    } result_t;

endpackage

`default_nettype wire

/* sv/xcfr_fsm.sv */
// Header hunt, payload count and XOR check state machine.
`default_nettype none

module xcfr_fsm #(
    parameter int PAYLOAD_BYTES = xcfr_pkg::DEFAULT_PAYLOAD_BYTES
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    output xcfr_pkg::result_t     result
);

    localparam int          LAST_COUNT = (PAYLOAD_BYTES < 1) ? 1 : PAYLOAD_BYTES;
    localparam logic [7:0]  LAST_IDX   = 8'(LAST_COUNT - 1);

    xcfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       acc_reg, acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= xcfr_pkg::PH_HUNT;
            count_reg <= '0;
            acc_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

    always_comb begin
        phase_next           = phase_reg;
        count_next           = count_reg;
        acc_next             = acc_reg;
        result.valid         = 1'b0;
        result.out_byte      = rx_byte;
        result.byte_index    = 8'd0;
        result.frame_end     = 1'b0;
        result.checksum_good = 1'b0;
        unique case (phase_reg)
            xcfr_pkg::PH_HUNT: begin
                if (rx_byte == xcfr_pkg::HDR_FIRST) begin
                    phase_next = xcfr_pkg::PH_HDR2;
                end
            end
            xcfr_pkg::PH_HDR2: begin
                if (rx_byte == xcfr_pkg::HDR_SECOND) begin
                    phase_next = xcfr_pkg::PH_DATA;
                    count_next = '0;
                    acc_next   = '0;
                end else begin
                    phase_next = xcfr_pkg::PH_HUNT;
                end
            end
            xcfr_pkg::PH_DATA: begin
                result.valid      = 1'b1;
                result.byte_index = count_reg;
                acc_next          = acc_reg ^ rx_byte;
                count_next        = count_reg + 8'd1;
                if (count_reg == LAST_IDX) begin
                    phase_next = xcfr_pkg::PH_CSUM;
                end
            end
            xcfr_pkg::PH_CSUM: begin
                result.valid         = 1'b1;
                result.frame_end     = 1'b1;
                result.checksum_good = (rx_byte == acc_reg);
                phase_next           = xcfr_pkg::PH_HUNT;
                count_next           = '0;
                acc_next             = '0;
            end
            default: begin
                phase_next = xcfr_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/xor_checked_frame_receiver.sv */
// Top level of the XOR-checked frame receiver with its two-entry result buffer.
`default_nettype none

// Takes one received byte per cycle and deframes it: hunts for 0xAA then 0xBB,
// passes PAYLOAD_BYTES payload bytes out with their index, then checks the
// next byte against the XOR of the payload and emits a frame-end result with
// a good/bad flag. Header and hunted-over bytes produce nothing. Each byte is
// handled in the cycle it is accepted, and its result is registered. Results
// pass through an output register backed by one skid register, so a byte is
// accepted every cycle as long as the skid register is empty; s_ready drops
// only when two results wait for m_ready.

module xor_checked_frame_receiver #(
    parameter int PAYLOAD_BYTES = xcfr_pkg::DEFAULT_PAYLOAD_BYTES
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [7:0]      m_byte_index,
    output logic            m_frame_end,
    output logic            m_checksum_good
);

    xcfr_pkg::result_t result;
    xcfr_pkg::result_t out_reg;
    xcfr_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              accept;
    logic              pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    xcfr_fsm #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && result.valid) begin
            if (out_valid_reg && !pop) begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end else begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_reg.out_byte;
    assign m_byte_index    = out_reg.byte_index;
    assign m_frame_end     = out_reg.frame_end;
    assign m_checksum_good = out_reg.checksum_good;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    a_end_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> (m_byte_index == 8'd0))
        else $error("frame-end result carries a nonzero index");

    a_good_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_end) |-> !m_checksum_good)
        else $error("payload result flags a good checksum");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> !s_ready)
        else $error("input accepted while both result registers are full");

endmodule

`default_nettype wire
